/* sv/ncs_pkg.sv */
package ncs_pkg;

  localparam int MAX_KNOTS_DEF = 64;

  localparam int DIV_NW = 51;
  localparam int DIV_DW = 35;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_BELOW = 3'd1,
    STAT_ABOVE = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_FEW   = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] x;
  } knot_t;

  typedef struct packed {
    logic signed [31:0] d;
    logic signed [31:0] c;
    logic signed [31:0] b;
    logic signed [31:0] z;
    logic signed [31:0] mu;
    logic signed [31:0] s;
    logic signed [31:0] h;
  } coef_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SC_RD, S_SC_CMP, S_SC_END, S_SH_RD, S_SH_WR, S_INS,
    S_SV_RD0, S_SV_LAT0, S_SV_LD, S_SV_SDS, S_SV_SDW, S_SV_M0, S_SV_M1, S_SV_M2,
    S_SV_MUS, S_SV_MUW, S_SV_ZS, S_SV_ZW, S_SV_WR,
    S_BK_RD, S_BK_LAT, S_BK_M0, S_BK_M1, S_BK_TS, S_BK_TW, S_BK_M2, S_BK_M3,
    S_BK_DS, S_BK_DW,
    S_EV_RD, S_EV_LAT, S_EV_T, S_EV_M0, S_EV_M1, S_EV_M2, S_EV_M3, S_EV_M4, S_EV_M5,
    S_OUT
  } state_e;

  function automatic logic signed [63:0] sx32(input logic signed [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

/* sv/ncs_ram.sv */
module ncs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ncs_div.sv */
module ncs_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ncs_pkg::DIV_NW-1:0] num_i,
  input  logic signed [ncs_pkg::DIV_DW-1:0] den_i,
  output logic                              done_o,
  output logic signed [31:0]                quo_o
);

  import ncs_pkg::*;

  localparam logic [DIV_NW-1:0] QMAX    = DIV_NW'(64'h7FFF_FFFF);
  localparam logic [DIV_NW-1:0] QMINMAG = DIV_NW'(64'h8000_0000);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] nsh_q, nsh_d, nsh_step;
  logic [DIV_DW-1:0] rem_q, rem_d, rem_sh, rem_step, dmag_q, dmag_d;
  logic              neg_q, neg_d, dz_q, dz_d, npos_q, npos_d, nneg_q, nneg_d;
  logic [31:0]       quo_q, quo_d;
  logic              ge;

  assign rem_sh   = {rem_q[DIV_DW-2:0], nsh_q[DIV_NW-1]};
  assign ge       = (rem_sh >= dmag_q);
  assign rem_step = ge ? (rem_sh - dmag_q) : rem_sh;
  assign nsh_step = {nsh_q[DIV_NW-2:0], ge};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nsh_d  = nsh_q;
    rem_d  = rem_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    npos_d = npos_q;
    nneg_d = nneg_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      nsh_d  = num_i[DIV_NW-1] ? (~num_i + 1'b1) : num_i;
      rem_d  = '0;
      dmag_d = den_i[DIV_DW-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[DIV_NW-1] ^ den_i[DIV_DW-1];
      dz_d   = (den_i == '0);
      nneg_d = num_i[DIV_NW-1];
      npos_d = !num_i[DIV_NW-1] && (num_i != '0);
    end else if (busy_q) begin
      nsh_d = nsh_step;
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (dz_q) begin
          quo_d = npos_q ? 32'h7FFF_FFFF : (nneg_q ? 32'h8000_0000 : 32'h0);
        end else if (neg_q) begin
          quo_d = (nsh_step > QMINMAG) ? 32'h8000_0000 : (~nsh_step[31:0] + 32'd1);
        end else begin
          quo_d = (nsh_step > QMAX) ? 32'h7FFF_FFFF : nsh_step[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nsh_q  <= nsh_d;
    rem_q  <= rem_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    dz_q   <= dz_d;
    npos_q <= npos_d;
    nneg_q <= nneg_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* sv/natural_cubic_spline_interpolator.sv */
// Natural cubic spline interpolator on a sorted knot table, signed Q16.16. One request is
// taken at a time and gives one result. An add request scans the stored knots and, for a
// new x, moves every knot above it up. An evaluate request with unchanged knots scans the
// table and then works out the segment polynomial. After the table has changed, the first
// evaluate also solves the spline with the shared bit-serial divider: three divisions per
// knot on the forward sweep, but one for the first, and one on the backward sweep.
module natural_cubic_spline_interpolator #(
  parameter int MAX_KNOTS = ncs_pkg::MAX_KNOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // abscissa [31:0], ordinate [63:32]
  input  logic [0:0]  s_axis_tuser,   // operation [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // interpolated [31:0]
  output logic [2:0]  m_axis_tuser    // status [2:0]
);

  import ncs_pkg::*;

  localparam int AW  = $clog2(MAX_KNOTS);
  localparam int CW  = $clog2(MAX_KNOTS + 1);
  localparam int KW  = $bits(knot_t);
  localparam int CFW = $bits(coef_t);

  localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

  state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d, less_q, less_d;
  logic          stale_q, stale_d, match_q, match_d, mv_q, mv_d;

  op_e     op_q, op_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, my_q, my_d;
  knot_t   kw_q, kw_d;
  coef_t   cw_q, cw_d;
  logic signed [31:0] xp_q, xp_d, xc_q, xc_d, yc_q, yc_d, hp_q, hp_d, sp_q, sp_d;
  logic signed [31:0] mup_q, mup_d, zp_q, zp_d, hc_q, hc_d, sc_q, sc_d, l_q, l_d;
  logic signed [32:0] nz_q, nz_d;
  logic signed [31:0] mu_q, mu_d, z_q, z_d, c1_q, c1_d, c0_q, c0_d, th_q, th_d;
  logic signed [31:0] bb_q, bb_d, t_q, t_d, t2_q, t2_d, t3_q, t3_d;
  logic signed [35:0] acc_q, acc_d;
  logic signed [31:0] rv_q, rv_d, md_q, md_d;
  status_e rs_q, rs_d, ms_q, ms_d;
  logic signed [63:0] p_q, p_d;
  logic [32:0]        tm_q, tm_d;
  logic               tn_q, tn_d;

  logic          knot_we, coef_we;
  logic [AW-1:0] knot_waddr, knot_raddr, coef_waddr, coef_raddr;
  knot_t         knot_wdata, knot_rdata;
  coef_t         coef_wdata, coef_rdata;

  logic                       div_start, div_done;
  logic signed [63:0]         dnum64, dden64;
  logic signed [DIV_NW-1:0]   div_num;
  logic signed [DIV_DW-1:0]   div_den;
  logic signed [31:0]         div_quo;

  logic signed [31:0] mul_a, mul_b, qm;
  logic signed [31:0] h_new, l_new, alpha, c0_new, bb_new, t_new;
  logic signed [63:0] nz64, ysum64, accsum64;
  logic signed [63:0] tsum64, tabs64;
  logic [64:0]        tprod;
  logic [31:0]        tquo;
  logic [CW-1:0]      idx_p1, idx_p2, idx_m1;

  ncs_ram #(.WIDTH(KW), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (knot_we),
    .waddr_i (knot_waddr),
    .wdata_i (knot_wdata),
    .raddr_i (knot_raddr),
    .rdata_o (knot_rdata)
  );

  ncs_ram #(.WIDTH(CFW), .DEPTH(MAX_KNOTS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  ncs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign p_d = mul_a * mul_b;
  assign qm  = sat32(p_q >>> 16);

  assign idx_p1 = idx_q + CW'(1);
  assign idx_p2 = idx_q + CW'(2);
  assign idx_m1 = idx_q - CW'(1);

  assign h_new    = sat32(sx32(knot_rdata.x) - sx32(xc_q));
  assign l_new    = sat32(64'sd2 * (sx32(kw_q.x) - sx32(xp_q)) - sx32(qm));
  assign alpha    = sat32(64'sd3 * sx32(sc_q) - 64'sd3 * sx32(sp_q));
  assign nz64     = sx32(alpha) - sx32(qm);
  assign c0_new   = sat32(sx32(cw_q.z) - sx32(qm));
  assign bb_new   = sat32(sx32(cw_q.s) - sx32(qm));
  assign t_new    = sat32(sx32(x_q) - sx32(kw_q.x));
  assign ysum64   = sx32(kw_q.y) + sx32(qm);
  assign accsum64 = {{28{acc_q[35]}}, acc_q} + sx32(qm);

  // Division by three of a magnitude below 2^33 by the reciprocal (2^33 + 1) / 3.
  assign tsum64 = sx32(c1_q) + 64'sd2 * sx32(c0_q);
  assign tabs64 = tsum64[63] ? -tsum64 : tsum64;
  assign tprod  = 65'(tm_q) * 65'(THIRD_RECIP);
  assign tquo   = tprod[64:33];

  assign div_num = dnum64[DIV_NW-1:0];
  assign div_den = dden64[DIV_DW-1:0];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    less_d  = less_q;
    stale_d = stale_q;
    match_d = match_q;
    mv_d    = mv_q;
    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    my_d    = my_q;
    kw_d    = kw_q;
    cw_d    = cw_q;
    xp_d    = xp_q;
    xc_d    = xc_q;
    yc_d    = yc_q;
    hp_d    = hp_q;
    sp_d    = sp_q;
    mup_d   = mup_q;
    zp_d    = zp_q;
    hc_d    = hc_q;
    sc_d    = sc_q;
    l_d     = l_q;
    nz_d    = nz_q;
    mu_d    = mu_q;
    z_d     = z_q;
    c1_d    = c1_q;
    c0_d    = c0_q;
    th_d    = th_q;
    bb_d    = bb_q;
    t_d     = t_q;
    t2_d    = t2_q;
    t3_d    = t3_q;
    acc_d   = acc_q;
    rv_d    = rv_q;
    rs_d    = rs_q;
    md_d    = md_q;
    ms_d    = ms_q;
    tm_d    = tm_q;
    tn_d    = tn_q;

    s_axis_tready = 1'b0;
    knot_we    = 1'b0;
    knot_waddr = idx_q[AW-1:0];
    knot_wdata = '{x: x_q, y: y_q};
    knot_raddr = idx_q[AW-1:0];
    coef_we    = 1'b0;
    coef_waddr = idx_q[AW-1:0];
    coef_wdata = cw_q;
    coef_raddr = idx_q[AW-1:0];
    div_start  = 1'b0;
    dnum64     = '0;
    dden64     = '0;
    mul_a      = t_q;
    mul_b      = t_q;

    if (mv_q && m_axis_tready) begin
      mv_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser[0]);
          x_d     = s_axis_tdata[31:0];
          y_d     = s_axis_tdata[63:32];
          idx_d   = '0;
          less_d  = '0;
          match_d = 1'b0;
          if (op_e'(s_axis_tuser[0]) == OP_ADD) begin
            state_d = (count_q == '0) ? S_SC_END : S_SC_RD;
          end else if (count_q < CW'(3)) begin
            rv_d    = '0;
            rs_d    = STAT_FEW;
            state_d = S_OUT;
          end else begin
            state_d = stale_q ? S_SV_RD0 : S_SC_RD;
          end
        end
      end

      S_SC_RD: begin
        state_d = S_SC_CMP;
      end

      S_SC_CMP: begin
        if (knot_rdata.x == x_q) begin
          match_d = 1'b1;
          my_d    = knot_rdata.y;
          state_d = S_SC_END;
        end else begin
          if (knot_rdata.x < x_q) begin
            less_d = less_q + CW'(1);
          end
          if (idx_p1 == count_q) begin
            state_d = S_SC_END;
          end else begin
            idx_d   = idx_p1;
            state_d = S_SC_RD;
          end
        end
      end

      S_SC_END: begin
        rv_d = '0;
        rs_d = STAT_OK;
        if (op_q == OP_ADD) begin
          if (match_q) begin
            knot_we = 1'b1;
            stale_d = 1'b1;
            state_d = S_OUT;
          end else if (count_q == CW'(MAX_KNOTS)) begin
            rs_d    = STAT_FULL;
            state_d = S_OUT;
          end else begin
            idx_d   = count_q;
            state_d = (count_q != less_q) ? S_SH_RD : S_INS;
          end
        end else if (match_q) begin
          rv_d    = my_q;
          state_d = S_OUT;
        end else if (less_q == '0) begin
          rs_d    = STAT_BELOW;
          state_d = S_OUT;
        end else if (less_q == count_q) begin
          rs_d    = STAT_ABOVE;
          state_d = S_OUT;
        end else begin
          idx_d   = less_q - CW'(1);
          state_d = S_EV_RD;
        end
      end

      S_SH_RD: begin
        knot_raddr = idx_m1[AW-1:0];
        state_d    = S_SH_WR;
      end

      S_SH_WR: begin
        knot_we    = 1'b1;
        knot_wdata = knot_rdata;
        idx_d      = idx_m1;
        state_d    = (idx_m1 != less_q) ? S_SH_RD : S_INS;
      end

      S_INS: begin
        knot_we    = 1'b1;
        knot_waddr = less_q[AW-1:0];
        count_d    = count_q + CW'(1);
        stale_d    = 1'b1;
        state_d    = S_OUT;
      end

      S_SV_RD0: begin
        state_d = S_SV_LAT0;
      end

      S_SV_LAT0: begin
        xc_d       = knot_rdata.x;
        yc_d       = knot_rdata.y;
        knot_raddr = idx_p1[AW-1:0];
        state_d    = S_SV_LD;
      end

      S_SV_LD: begin
        kw_d    = knot_rdata;
        hc_d    = h_new;
        state_d = S_SV_SDS;
      end

      S_SV_SDS: begin
        div_start = 1'b1;
        dnum64    = (sx32(kw_q.y) - sx32(yc_q)) <<< 16;
        dden64    = sx32(hc_q);
        state_d   = S_SV_SDW;
      end

      S_SV_SDW: begin
        if (div_done) begin
          sc_d = div_quo;
          if (idx_q == '0) begin
            mu_d    = '0;
            z_d     = '0;
            state_d = S_SV_WR;
          end else begin
            state_d = S_SV_M0;
          end
        end
      end

      S_SV_M0: begin
        mul_a   = hp_q;
        mul_b   = mup_q;
        state_d = S_SV_M1;
      end

      S_SV_M1: begin
        l_d     = l_new;
        mul_a   = hp_q;
        mul_b   = zp_q;
        state_d = S_SV_M2;
      end

      S_SV_M2: begin
        nz_d    = nz64[32:0];
        state_d = S_SV_MUS;
      end

      S_SV_MUS: begin
        div_start = 1'b1;
        dnum64    = sx32(hc_q) <<< 16;
        dden64    = sx32(l_q);
        state_d   = S_SV_MUW;
      end

      S_SV_MUW: begin
        if (div_done) begin
          mu_d    = div_quo;
          state_d = S_SV_ZS;
        end
      end

      S_SV_ZS: begin
        div_start = 1'b1;
        dnum64    = {{31{nz_q[32]}}, nz_q} <<< 16;
        dden64    = sx32(l_q);
        state_d   = S_SV_ZW;
      end

      S_SV_ZW: begin
        if (div_done) begin
          z_d     = div_quo;
          state_d = S_SV_WR;
        end
      end

      S_SV_WR: begin
        coef_we    = 1'b1;
        coef_wdata = '{h: hc_q, s: sc_q, mu: mu_q, z: z_q, b: '0, c: '0, d: '0};
        hp_d       = hc_q;
        sp_d       = sc_q;
        mup_d      = mu_q;
        zp_d       = z_q;
        xp_d       = xc_q;
        xc_d       = kw_q.x;
        yc_d       = kw_q.y;
        knot_raddr = idx_p2[AW-1:0];
        if (({1'b0, idx_q} + (CW + 1)'(2)) < {1'b0, count_q}) begin
          idx_d   = idx_p1;
          state_d = S_SV_LD;
        end else begin
          c1_d    = '0;
          state_d = S_BK_RD;
        end
      end

      S_BK_RD: begin
        state_d = S_BK_LAT;
      end

      S_BK_LAT: begin
        cw_d    = coef_rdata;
        state_d = S_BK_M0;
      end

      S_BK_M0: begin
        mul_a   = cw_q.mu;
        mul_b   = c1_q;
        state_d = S_BK_M1;
      end

      S_BK_M1: begin
        c0_d    = c0_new;
        state_d = S_BK_TS;
      end

      S_BK_TS: begin
        tn_d    = tsum64[63];
        tm_d    = tabs64[32:0];
        state_d = S_BK_TW;
      end

      S_BK_TW: begin
        th_d    = tn_q ? (32'd0 - tquo) : tquo;
        state_d = S_BK_M2;
      end

      S_BK_M2: begin
        mul_a   = cw_q.h;
        mul_b   = th_q;
        state_d = S_BK_M3;
      end

      S_BK_M3: begin
        bb_d    = bb_new;
        state_d = S_BK_DS;
      end

      S_BK_DS: begin
        div_start = 1'b1;
        dnum64    = (sx32(c1_q) - sx32(c0_q)) <<< 16;
        dden64    = 64'sd3 * sx32(cw_q.h);
        state_d   = S_BK_DW;
      end

      S_BK_DW: begin
        if (div_done) begin
          coef_we    = 1'b1;
          coef_wdata = '{h: cw_q.h, s: cw_q.s, mu: cw_q.mu, z: cw_q.z,
                         b: bb_q, c: c0_q, d: div_quo};
          c1_d       = c0_q;
          if (idx_q == '0) begin
            stale_d = 1'b0;
            less_d  = '0;
            match_d = 1'b0;
            state_d = S_SC_RD;
          end else begin
            idx_d   = idx_m1;
            state_d = S_BK_RD;
          end
        end
      end

      S_EV_RD: begin
        state_d = S_EV_LAT;
      end

      S_EV_LAT: begin
        kw_d    = knot_rdata;
        cw_d    = coef_rdata;
        state_d = S_EV_T;
      end

      S_EV_T: begin
        t_d     = t_new;
        state_d = S_EV_M0;
      end

      S_EV_M0: begin
        state_d = S_EV_M1;
      end

      S_EV_M1: begin
        t2_d    = qm;
        mul_a   = cw_q.b;
        mul_b   = t_q;
        state_d = S_EV_M2;
      end

      S_EV_M2: begin
        acc_d   = ysum64[35:0];
        mul_a   = t2_q;
        mul_b   = t_q;
        state_d = S_EV_M3;
      end

      S_EV_M3: begin
        t3_d    = qm;
        mul_a   = cw_q.c;
        mul_b   = t2_q;
        state_d = S_EV_M4;
      end

      S_EV_M4: begin
        acc_d   = accsum64[35:0];
        mul_a   = cw_q.d;
        mul_b   = t3_q;
        state_d = S_EV_M5;
      end

      S_EV_M5: begin
        rv_d    = sat32(accsum64);
        rs_d    = STAT_OK;
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!mv_q || m_axis_tready) begin
          mv_d    = 1'b1;
          md_d    = rv_q;
          ms_d    = rs_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      less_q  <= '0;
      stale_q <= 1'b1;
      match_q <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      less_q  <= less_d;
      stale_q <= stale_d;
      match_q <= match_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    x_q   <= x_d;
    y_q   <= y_d;
    my_q  <= my_d;
    kw_q  <= kw_d;
    cw_q  <= cw_d;
    xp_q  <= xp_d;
    xc_q  <= xc_d;
    yc_q  <= yc_d;
    hp_q  <= hp_d;
    sp_q  <= sp_d;
    mup_q <= mup_d;
    zp_q  <= zp_d;
    hc_q  <= hc_d;
    sc_q  <= sc_d;
    l_q   <= l_d;
    nz_q  <= nz_d;
    mu_q  <= mu_d;
    z_q   <= z_d;
    c1_q  <= c1_d;
    c0_q  <= c0_d;
    th_q  <= th_d;
    bb_q  <= bb_d;
    t_q   <= t_d;
    t2_q  <= t2_d;
    t3_q  <= t3_d;
    acc_q <= acc_d;
    rv_q  <= rv_d;
    rs_q  <= rs_d;
    md_q  <= md_d;
    ms_q  <= ms_d;
    p_q   <= p_d;
    tm_q  <= tm_d;
    tn_q  <= tn_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = ms_q;

endmodule

/* sv/ncs_chk.sv */
module ncs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  import ncs_pkg::*;

  // A result that has not been taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  // Any status other than ok carries a zero value.
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
    else $error("non-zero value with a failing status");

  // One request at a time: the block is busy in the cycle after it takes one.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is in progress");

endmodule

bind natural_cubic_spline_interpolator ncs_chk u_ncs_chk (.*);
